FILE: src/key_ring_rotation_table_macros.svh
// ============================================================================
// Assertion macros for the key ring rotation table.
// ============================================================================
`ifndef KEY_RING_ROTATION_TABLE_MACROS_SVH
`define KEY_RING_ROTATION_TABLE_MACROS_SVH

// Implication checked on every clock edge while out of reset.
`define KRRT_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("key ring rotation table check failed");

// Next-cycle implication checked while out of reset.
`define KRRT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("key ring rotation table sequencing check failed");

`endif

FILE: src/krrt_pkg.sv
// ============================================================================
// krrt_pkg
// Shared widths, entry type and command codes of the key ring rotation table.
// ============================================================================
package krrt_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int TIME_W     = 48;
    localparam int REG_W      = 24;
    localparam int KEY_W      = 256;

    localparam logic CMD_ROTATE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic CFG_ROTATE_PERIOD = 1'b0;
    localparam logic CFG_VERIFY_TAIL   = 1'b1;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] created;
        logic [TIME_W-1:0] expires;
    } entry_t;

endpackage

FILE: src/krrt_entry_ram.sv
// ============================================================================
// krrt_entry_ram
// Synchronous entry memory: one write port, one read port, registered read.
// ============================================================================
module krrt_entry_ram
    import krrt_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [SLOT_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [NUM_SLOTS];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/key_ring_rotation_table.sv
// ============================================================================
// key_ring_rotation_table
// Newest-first table of 256-bit keys with pruning of expired entries and
// rotation of a fresh key in at the front.
// ============================================================================
// Channel  Direction  Handshake
// in       input      in_valid / in_ready
// out      output     out_valid / out_ready
// cfg      input      cfg_we (no wait)
//
// A read returns its result word through one memory read in ST_RD_WAIT and
// the result register, loaded in ST_RD_DONE.
// A rotate walks the table through the single read port: a read and a check
// per held slot for pruning, a read of the front slot to check the due time,
// then a read and a write per moved slot and a final write to insert, or a
// finish step without an insertion.
// Reset clears the count and state and sets both config registers to 86400;
// memory entries beyond the count are never used, so the memory needs no clearing pass.
// A stalled result holds in the output register; a new word waits meanwhile
// and is taken at the earliest the cycle after the result word leaves.
// ============================================================================
module key_ring_rotation_table
    import krrt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [23:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          command,
    input  logic [47:0]   now_time,
    input  logic          fresh_ok,
    input  logic [63:0]   fresh_word0,
    input  logic [63:0]   fresh_word1,
    input  logic [63:0]   fresh_word2,
    input  logic [63:0]   fresh_word3,
    input  logic [1:0]    slot_index,
    output logic          out_valid,
    input  logic          out_ready,
    output logic          changed,
    output logic [2:0]    entry_count,
    output logic [2:0]    pruned_count,
    output logic          slot_valid,
    output logic [63:0]   slot_word0,
    output logic [63:0]   slot_word1,
    output logic [63:0]   slot_word2,
    output logic [63:0]   slot_word3,
    output logic [47:0]   slot_created,
    output logic [47:0]   slot_expires
);

`include "key_ring_rotation_table_macros.svh"

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RD_WAIT = 4'd1;
    localparam logic [3:0] ST_RD_DONE = 4'd2;
    localparam logic [3:0] ST_PR_REQ  = 4'd3;
    localparam logic [3:0] ST_PR_CHK  = 4'd4;
    localparam logic [3:0] ST_DUE_REQ = 4'd5;
    localparam logic [3:0] ST_DUE_CHK = 4'd6;
    localparam logic [3:0] ST_SH_REQ  = 4'd7;
    localparam logic [3:0] ST_SH_WR   = 4'd8;
    localparam logic [3:0] ST_INSERT  = 4'd9;
    localparam logic [3:0] ST_FINISH  = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [REG_W-1:0]  period_reg, tail_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  kept_reg, kept_next;
    logic              fresh_ok_reg;
    logic [KEY_W-1:0]  fresh_key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              out_valid_reg;
    logic              res_load;
    logic              res_changed_next;
    logic [CNT_W-1:0]  res_pruned_next;
    logic              res_slot_valid_next;
    entry_t            res_entry_next;
    logic              res_changed_reg;
    logic [CNT_W-1:0]  res_count_reg, res_pruned_reg;
    logic              res_slot_valid_reg;
    entry_t            res_entry_reg;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr, rd_addr;
    entry_t            wr_data, rd_data;

    logic [TIME_W+1:0] exp_sum;
    logic [TIME_W:0]   due_sum;
    logic [CNT_W-1:0]  keep_cnt;

    krrt_entry_ram u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // Saturating expiry for the fresh key and due time of the front entry.
    assign exp_sum  = {2'b00, now_reg} + {{(TIME_W-REG_W+2){1'b0}}, period_reg}
                    + {{(TIME_W-REG_W+2){1'b0}}, tail_reg};
    assign due_sum  = {1'b0, rd_data.created} + {{(TIME_W-REG_W+1){1'b0}}, period_reg};
    assign keep_cnt = (kept_reg < CNT_W'(NUM_SLOTS)) ? kept_reg : CNT_W'(NUM_SLOTS - 1);

    // Sequencer: reads one slot at a time, writes back the moved entry.
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        kept_next           = kept_reg;
        wr_en               = 1'b0;
        wr_addr             = kept_reg[SLOT_W-1:0];
        wr_data             = rd_data;
        rd_addr             = idx_reg[SLOT_W-1:0];
        res_load            = 1'b0;
        res_changed_next    = 1'b0;
        res_pruned_next     = '0;
        res_slot_valid_next = 1'b0;
        res_entry_next      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = slot_index[SLOT_W-1:0];
                if (in_valid && in_ready)
                begin
                    idx_next  = '0;
                    kept_next = '0;
                    state_next = (command == CMD_READ) ? ST_RD_WAIT : ST_PR_REQ;
                end
            end
            ST_RD_WAIT:
            begin
                rd_addr    = slot_reg;
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                res_load = 1'b1;
                if (CNT_W'(slot_reg) < count_reg)
                begin
                    res_slot_valid_next = 1'b1;
                    res_entry_next      = rd_data;
                end
                state_next = ST_IDLE;
            end
            ST_PR_REQ:
            begin
                state_next = (idx_reg < count_reg) ? ST_PR_CHK : ST_DUE_REQ;
            end
            ST_PR_CHK:
            begin
                // Keep survivors, compacting them toward the front.
                if (now_reg < rd_data.expires)
                begin
                    wr_en     = 1'b1;
                    kept_next = kept_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_PR_REQ;
                rd_addr    = idx_next[SLOT_W-1:0];
            end
            ST_DUE_REQ:
            begin
                rd_addr    = '0;
                state_next = ST_DUE_CHK;
            end
            ST_DUE_CHK:
            begin
                if (fresh_ok_reg && ((kept_reg == '0) || ({1'b0, now_reg} >= due_sum)))
                begin
                    idx_next   = keep_cnt;
                    state_next = ST_SH_REQ;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SH_REQ:
            begin
                // Read slot idx-1 to move it down to idx.
                rd_addr    = idx_reg[SLOT_W-1:0] - 1'b1;
                state_next = (idx_reg == '0) ? ST_INSERT : ST_SH_WR;
            end
            ST_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[SLOT_W-1:0];
                idx_next   = idx_reg - 1'b1;
                state_next = ST_SH_REQ;
            end
            ST_INSERT:
            begin
                wr_en           = 1'b1;
                wr_addr         = '0;
                wr_data.key     = fresh_key_reg;
                wr_data.created = now_reg;
                wr_data.expires = exp_sum[TIME_W+1:TIME_W] != 2'b00 ? '1 : exp_sum[TIME_W-1:0];
                res_load         = 1'b1;
                res_changed_next = 1'b1;
                res_pruned_next  = count_reg - kept_reg;
                count_next       = keep_cnt + 1'b1;
                state_next       = ST_IDLE;
            end
            ST_FINISH:
            begin
                res_load         = 1'b1;
                res_changed_next = (count_reg != kept_reg);
                res_pruned_next  = count_reg - kept_reg;
                count_next       = kept_reg;
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
            period_reg    <= REG_W'(86400);
            tail_reg      <= REG_W'(86400);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            kept_reg  <= kept_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROTATE_PERIOD)
                begin
                    period_reg <= cfg_data;
                end
                else
                begin
                    tail_reg <= cfg_data;
                end
            end
        end
    end

    // Captured item and result word.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            now_reg       <= now_time;
            fresh_ok_reg  <= fresh_ok;
            fresh_key_reg <= {fresh_word3, fresh_word2, fresh_word1, fresh_word0};
            slot_reg      <= slot_index[SLOT_W-1:0];
        end
        if (res_load)
        begin
            res_changed_reg    <= res_changed_next;
            res_pruned_reg     <= res_pruned_next;
            res_count_reg      <= count_next;
            res_slot_valid_reg <= res_slot_valid_next;
            res_entry_reg      <= res_entry_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign changed      = res_changed_reg;
    assign entry_count  = 3'(res_count_reg);
    assign pruned_count = 3'(res_pruned_reg);
    assign slot_valid   = res_slot_valid_reg;
    assign slot_word0   = res_entry_reg.key[63:0];
    assign slot_word1   = res_entry_reg.key[127:64];
    assign slot_word2   = res_entry_reg.key[191:128];
    assign slot_word3   = res_entry_reg.key[255:192];
    assign slot_created = res_entry_reg.created;
    assign slot_expires = res_entry_reg.expires;

    `KRRT_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(NUM_SLOTS))
    `KRRT_ASSERT_IMP(a_kept_le_count, clk, rst_n, state_reg != ST_IDLE, kept_reg <= count_reg)
    `KRRT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready,
        state_reg != ST_IDLE)

endmodule

FILE: tb/sv/tb_key_ring_rotation_table.sv
// ----------------------------------------------------------------------------
// Key ring rotation table testbench
// Drives rotate and read words through the valid/ready input and checks every
// result word against a typed answer or a local model of the table. A directed
// table comes first, then random rotate and read sequences with advancing time,
// random stalls and one long hold-off on the result side, and register changes between phases.
// ----------------------------------------------------------------------------
module tb_key_ring_rotation_table;
    import krrt_pkg::*;

    localparam int          TIMEOUT_CYCLES = 20000;
    localparam logic [47:0] TMAX           = 48'hFFFF_FFFF_FFFF;
    localparam int          RANDOM_WORDS   = 250;

    typedef struct packed {
        logic        command;
        logic [47:0] now_time;
        logic        fresh_ok;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [1:0]  slot;
    } request_t;

    typedef struct packed {
        logic        changed;
        logic [2:0]  entry_count;
        logic [2:0]  pruned_count;
        logic        slot_valid;
        logic [63:0] w0;
        logic [63:0] w1;
        logic [63:0] w2;
        logic [63:0] w3;
        logic [47:0] created;
        logic [47:0] expires;
    } answer_t;

    // Directed row: a request and, where it is obvious, the answer to expect.
    typedef struct packed {
        request_t req;
        logic     has_answer;
        answer_t  answer;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [47:0] now_time;
    logic        fresh_ok;
    logic [63:0] fresh_word0;
    logic [63:0] fresh_word1;
    logic [63:0] fresh_word2;
    logic [63:0] fresh_word3;
    logic [1:0]  slot_index;
    logic        out_valid;
    logic        out_ready;
    logic        changed;
    logic [2:0]  entry_count;
    logic [2:0]  pruned_count;
    logic        slot_valid;
    logic [63:0] slot_word0;
    logic [63:0] slot_word1;
    logic [63:0] slot_word2;
    logic [63:0] slot_word3;
    logic [47:0] slot_created;
    logic [47:0] slot_expires;

    // Local copy of the key table and registers.
    entry_t      ring [NUM_SLOTS];
    int          ring_count;
    logic [23:0] period_reg;
    logic [23:0] tail_reg;

    answer_t     pending_answers[$];
    int          error_count;
    int          idle_cycles;
    bit          hold_off;
    logic [47:0] clock_now;

    key_ring_rotation_table u_top (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // Applies one word to the table model and returns its answer.
    function automatic answer_t predict_table(input request_t r);
        answer_t a;
        int      kept;
        int      keep;
        logic    due;
        logic [49:0] exp_sum;
        a = '0;
        if (r.command == CMD_READ) begin
            a.entry_count = ring_count[2:0];
            if (r.slot < ring_count) begin
                a.slot_valid = 1'b1;
                {a.w3, a.w2, a.w1, a.w0} = ring[r.slot].key;
                a.created = ring[r.slot].created;
                a.expires = ring[r.slot].expires;
            end
            return a;
        end
        kept = 0;
        for (int i = 0; i < ring_count; i++) begin
            if (r.now_time < ring[i].expires) begin
                ring[kept] = ring[i];
                kept++;
            end
        end
        for (int i = kept; i < ring_count; i++)
            ring[i] = '0;
        a.pruned_count = 3'(ring_count - kept);
        a.changed = (ring_count != kept);
        ring_count = kept;
        due = (ring_count == 0) ||
              ({1'b0, r.now_time} >= {1'b0, ring[0].created} + period_reg);
        if (due && r.fresh_ok) begin
            keep = (ring_count < NUM_SLOTS) ? ring_count : NUM_SLOTS - 1;
            for (int i = keep; i > 0; i--)
                ring[i] = ring[i-1];
            exp_sum = r.now_time + period_reg + tail_reg;
            ring[0].key = {r.w3, r.w2, r.w1, r.w0};
            ring[0].created = r.now_time;
            ring[0].expires = (exp_sum > TMAX) ? TMAX : exp_sum[47:0];
            ring_count = keep + 1;
            a.changed = 1'b1;
        end
        a.entry_count = ring_count[2:0];
        return a;
    endfunction

    // Offers one word, waits for acceptance, and records its answer. A typed
    // answer is expected as given; otherwise the model's answer is expected.
    task automatic send_word(input request_t r, input logic has_answer,
                             input answer_t given);
        answer_t p;
        if ($urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 30) :
                    $urandom_range(1, 3)) @(posedge clk);
        end
        command     <= r.command;
        now_time    <= r.now_time;
        fresh_ok    <= r.fresh_ok;
        fresh_word0 <= r.w0;
        fresh_word1 <= r.w1;
        fresh_word2 <= r.w2;
        fresh_word3 <= r.w3;
        slot_index  <= r.slot;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_table(r);
        pending_answers.push_back(has_answer ? given : p);
    endtask

    task automatic drain_and_wait();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_ROTATE_PERIOD)
            period_reg = val;
        else
            tail_reg = val;
        @(posedge clk);
    endtask

    function automatic request_t random_word(input bit noise);
        request_t r;
        r.command  = ($urandom_range(0, 2) == 0) ? CMD_READ : CMD_ROTATE;
        r.fresh_ok = ($urandom_range(0, 7) != 0);
        r.w0 = {$urandom, $urandom};
        r.w1 = {$urandom, $urandom};
        r.w2 = {$urandom, $urandom};
        r.w3 = {$urandom, $urandom};
        r.slot = 2'($urandom);
        if (noise) begin
            r.now_time = 48'({$urandom, $urandom});
            r.fresh_ok = 1'($urandom);
        end else begin
            // Time mostly advances by up to twice the period plus four, sometimes back.
            if ($urandom_range(0, 15) == 0)
                clock_now = clock_now - $urandom_range(0, 2000);
            else
                clock_now = clock_now + $urandom_range(0, 2 * period_reg + 4);
            r.now_time = clock_now;
        end
        return r;
    endfunction

    // Result side: random stalls and checking against the oldest answer.
    always @(posedge clk) begin
        answer_t e;
        answer_t g;
        if (rst_n && out_valid && out_ready) begin
            g = {changed, entry_count, pruned_count, slot_valid, slot_word0,
                 slot_word1, slot_word2, slot_word3, slot_created, slot_expires};
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result word", 64'(1), 64'(0));
            end else begin
                e = pending_answers.pop_front();
                if (g.changed != e.changed)
                    report_mismatch("changed", 64'(g.changed), 64'(e.changed));
                if (g.entry_count != e.entry_count)
                    report_mismatch("entry_count", 64'(g.entry_count),
                                    64'(e.entry_count));
                if (g.pruned_count != e.pruned_count)
                    report_mismatch("pruned_count", 64'(g.pruned_count),
                                    64'(e.pruned_count));
                if (g.slot_valid != e.slot_valid)
                    report_mismatch("slot_valid", 64'(g.slot_valid),
                                    64'(e.slot_valid));
                if (g.w0 != e.w0) report_mismatch("slot_word0", g.w0, e.w0);
                if (g.w1 != e.w1) report_mismatch("slot_word1", g.w1, e.w1);
                if (g.w2 != e.w2) report_mismatch("slot_word2", g.w2, e.w2);
                if (g.w3 != e.w3) report_mismatch("slot_word3", g.w3, e.w3);
                if (g.created != e.created)
                    report_mismatch("slot_created", 64'(g.created), 64'(e.created));
                if (g.expires != e.expires)
                    report_mismatch("slot_expires", 64'(g.expires), 64'(e.expires));
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 2) != 0)
            out_ready <= 1'b1;
    end

    // Long receiver hold-off, counted in cycles here.
    initial begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (3000) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= TIMEOUT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        row_t        rows[$];
        request_t    r;
        answer_t     a;
        logic [23:0] periods[4];
        logic [23:0] tails[4];
        logic [255:0] ones;
        ones        = '1;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_ROTATE_PERIOD;
        cfg_data    = '0;
        in_valid    = 1'b0;
        command     = CMD_ROTATE;
        now_time    = '0;
        fresh_ok    = 1'b0;
        fresh_word0 = '0;
        fresh_word1 = '0;
        fresh_word2 = '0;
        fresh_word3 = '0;
        slot_index  = '0;
        error_count = 0;
        ring_count  = 0;
        period_reg  = 24'd86400;
        tail_reg    = 24'd86400;
        for (int i = 0; i < NUM_SLOTS; i++)
            ring[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty reads, bad randomness, saturation, fill.
        a = '0;
        r = '0; r.command = CMD_READ;
        rows.push_back('{r, 1'b1, a});
        r = '0; r.command = CMD_ROTATE; r.now_time = 48'd5;
        rows.push_back('{r, 1'b1, a});
        r.fresh_ok = 1'b1; r.w0 = '1; r.w1 = '1; r.w2 = '1; r.w3 = '1;
        a.changed = 1'b1; a.entry_count = 3'd1;
        rows.push_back('{r, 1'b1, a});
        r = '0; r.command = CMD_READ; r.slot = 2'd0;
        a = '0; a.entry_count = 3'd1; a.slot_valid = 1'b1;
        {a.w3, a.w2, a.w1, a.w0} = ones;
        a.created = 48'd5; a.expires = 48'd5 + 48'd172800;
        rows.push_back('{r, 1'b1, a});
        r.slot = 2'd3; a = '0; a.entry_count = 3'd1;
        rows.push_back('{r, 1'b1, a});
        for (int i = 1; i <= 5; i++) begin
            r = '0; r.command = CMD_ROTATE; r.fresh_ok = 1'b1;
            r.now_time = 48'd5 + 48'(i) * 48'd86400; r.w1 = 64'(i);
            rows.push_back('{r, 1'b0, '0});
        end
        r = '0; r.command = CMD_ROTATE; r.fresh_ok = 1'b1; r.now_time = TMAX;
        r.w3 = 64'h8000_0000_0000_0000;
        rows.push_back('{r, 1'b0, '0});
        for (int s = 0; s < 4; s++) begin
            r = '0; r.command = CMD_READ; r.slot = 2'(s);
            rows.push_back('{r, 1'b0, '0});
        end
        r = '0; r.command = CMD_ROTATE; r.fresh_ok = 1'b1; r.now_time = 48'd100;
        rows.push_back('{r, 1'b0, '0});
        foreach (rows[i])
            send_word(rows[i].req, rows[i].has_answer, rows[i].answer);
        drain_and_wait();

        // Random phases under different register settings.
        periods = '{24'd0, 24'd1, 24'hFFFFFF, 24'd50};
        tails   = '{24'hFFFFFF, 24'd0, 24'd100, 24'd37};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_ROTATE_PERIOD,
                      ph < 4 ? periods[ph] : 24'($urandom_range(1, 500)));
            write_reg(CFG_VERIFY_TAIL,
                      ph < 4 ? tails[ph] : 24'($urandom_range(0, 500)));
            clock_now = (ph == 2) ? TMAX - 48'd30000000 : 48'($urandom);
            for (int n = 0; n < RANDOM_WORDS; n++)
                send_word(random_word($urandom_range(0, 9) == 0), 1'b0, '0);
            drain_and_wait();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
